### sv/assert_macros.svh
// Assertion macros used by the encoder top level to check its own behavior.
// Each macro expects signals named clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/b64e_pkg.sv
// Types, constants and the character table of the Base64 stream encoder.
// No dependencies; every module of the encoder imports this package.
package b64e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } b64e_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } b64e_out_t;

  // One group of up to three bytes handed from the front end to the back end.
  typedef struct packed {
    logic [23:0] group;      // Bytes, first byte in the top bits, zero-filled.
    logic [1:0]  last_data;  // Index of the last alphabet character (1..3).
    logic        last;       // Group ends a message.
  } b64e_job_t;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='
  localparam logic [1:0] LAST_IDX = 2'd3;

  // Maps a 6-bit index onto the standard alphabet.
  function automatic logic [7:0] b64e_char(input logic [5:0] sx);
    logic [7:0] v;
    v = {2'b00, sx};
    priority if (sx < 6'd26) begin
      return v + 8'd65;           // 'A'..'Z'
    end else if (sx < 6'd52) begin
      return v + 8'd71;           // 'a'..'z'
    end else if (sx < 6'd62) begin
      return v - 8'd4;            // '0'..'9'
    end else if (sx == 6'd62) begin
      return 8'h2B;               // '+'
    end else begin
      return 8'h2F;               // '/'
    end
  endfunction

endpackage

### sv/b64e_front.sv
// Front end of the Base64 encoder: gathers bytes into groups of up to three.
// Depends on b64e_pkg.
module b64e_front
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  b64e_in_t  in_data,
  output logic      in_stall,
  input  logic      q_full,
  output logic      push,
  output b64e_job_t push_job
);

  logic [7:0] held0_r, held1_r;
  logic [1:0] count_r, count_nxt;
  logic [1:0] idx;
  logic       accept;

  // A count of three cannot occur; it is handled as an empty group.
  assign idx      = (count_r == 2'd3) ? 2'd0 : count_r;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && ((idx == 2'd2) || in_data.end_of_message);

  always_comb begin
    push_job.last = in_data.end_of_message;
    unique case (idx)
      2'd2: begin
        push_job.group     = {held0_r, held1_r, in_data.data_byte};
        push_job.last_data = 2'd3;
      end
      2'd1: begin
        push_job.group     = {held0_r, in_data.data_byte, 8'h00};
        push_job.last_data = 2'd2;
      end
      default: begin
        push_job.group     = {in_data.data_byte, 16'h0000};
        push_job.last_data = 2'd1;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      count_nxt = push ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !push) begin
      if (idx == 2'd0) begin
        held0_r <= in_data.data_byte;
      end else begin
        held1_r <= in_data.data_byte;
      end
    end
  end

endmodule

### sv/b64e_queue.sv
// Small FIFO of byte groups between the front and back ends of the encoder.
// Depends on b64e_pkg.
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64e_job_t push_job,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output b64e_job_t head_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64e_job_t       slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push_ok, pop_ok;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign push_ok    = push && !full;
  assign pop_ok     = pop && head_valid;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({push_ok, pop_ok})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push_ok) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### sv/b64e_back.sv
// Back end of the Base64 encoder: turns one queued group into four characters.
// Depends on b64e_pkg.
module b64e_back
  import b64e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  b64e_job_t head_job,
  output logic      pop,
  output logic [1:0] char_idx,
  output logic      out_valid,
  output b64e_out_t out_data,
  input  logic      out_stall
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  b64e_out_t  out_data_r, out_data_nxt;
  logic [5:0] sx;
  logic       load;

  assign load     = head_valid && (!out_valid_r || !out_stall);
  assign pop      = load && (idx_r == LAST_IDX);
  assign char_idx = idx_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    unique case (idx_r)
      2'd0:    sx = head_job.group[23:18];
      2'd1:    sx = head_job.group[17:12];
      2'd2:    sx = head_job.group[11:6];
      default: sx = head_job.group[5:0];
    endcase
  end

  always_comb begin
    out_data_nxt.out_char  = (idx_r <= head_job.last_data) ? b64e_char(sx) : PAD_CHAR;
    out_data_nxt.last_char = (idx_r == LAST_IDX) && head_job.last;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 2'd1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

### sv/base64_stream_encoder_unit.sv
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back and assert_macros.svh.

// The encoder takes one raw byte per accepted input request and returns
// Base64 characters one per accepted output request. Every third byte of a
// message, and the byte flagged as the end of the message, closes a group,
// which yields exactly four characters; a short final group is zero-filled and
// padded with '=' to four characters, and last_char marks the final character
// of the message. Input bytes are taken at one per cycle as long as the group
// queue (QUEUE_DEPTH groups) has room; the output side drains one character a
// cycle while out_stall is low, so under continuous traffic the single output
// register sets the throughput. A byte that closes a group is written into
// the queue, and its characters are then loaded from the queue head into the
// output register. Bytes that do not close a group are held and give no output.
module base64_stream_encoder_unit
  import b64e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  b64e_in_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output b64e_out_t out_data,
  input  logic      out_stall
);

`include "assert_macros.svh"

  // Front end to queue.
  logic      push;
  b64e_job_t push_job;
  logic      q_full;

  // Queue to back end.
  logic      pop;
  logic      head_valid;
  b64e_job_t head_job;
  logic [1:0] char_idx;

  b64e_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // The queue decouples byte intake from character output so the front end
  // keeps accepting bytes while a group is still being emitted.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back end keeps the head group in the queue until its fourth
  // character has been loaded into the output register.
  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .char_idx   (char_idx),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall)
  );

  // A group that ends a message is queued or already on the output next cycle.
  `ASSERT_NEXT(a_eom_queued, in_valid && !in_stall && in_data.end_of_message, head_valid || out_valid, "end of message lost")
  // Padding characters come back to back up to the closing one.
  `ASSERT_NEXT(a_pad_run, out_valid && !out_stall && out_data.out_char == PAD_CHAR && !out_data.last_char, out_valid && out_data.out_char == PAD_CHAR, "padding run broken")
  // The character position only moves while a group is in progress.
  `ASSERT_IMPL(a_idx_idle, !head_valid, char_idx == 2'd0, "character position set without a group")

endmodule

### tb/tb_base64_stream_encoder_unit.sv
// Self-checking testbench for the streaming Base64 encoder top level.
// Depends on b64e_pkg for the request types and the pad character; predicts
// every output character locally and compares it with the block's output.
module tb_base64_stream_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import b64e_pkg::*;

  localparam int CLK_PERIOD = 4;

  // The standard alphabet packed into one vector. Index 0 ('A') sits in the
  // top byte, so character v is found at bit 8*(63-v).
  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  b64e_in_t  in_data;
  logic      in_stall;
  logic      out_valid;
  b64e_out_t out_data;
  logic      out_stall;

  // Local copy of the encoder state: bytes of the open group and their count.
  logic [7:0] enc_held [2];
  logic [1:0] enc_count;

  // Characters predicted but not yet seen on the output, oldest first.
  b64e_out_t pending_chars [$];

  // Idle controls. Each test turns the random gaps on either side on or off;
  // hold_request asks the output side for one long stall, counted down there.
  bit in_gaps_on;
  bit out_gaps_on;
  int hold_request;

  int errors;
  int bytes_sent;
  int messages_sent;
  int chars_checked;

  base64_stream_encoder_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] alphabet_char(input logic [5:0] sx);
    return B64_ALPHABET[8 * (63 - int'(sx)) +: 8];
  endfunction

  // Advances the local encoder by one accepted byte and queues the characters
  // it must produce. A byte that neither closes a group nor ends the message
  // is only held. A closed group gives four characters; a short final group
  // is zero-filled, gives one character more than the bytes it holds, and is
  // padded with '=' up to four. The last flag goes on the fourth character
  // only when the byte ends the message.
  function automatic void encode_into_pending(input logic [7:0] b, input logic eom);
    logic [23:0] grp;
    int          nchars;
    b64e_out_t   ch;
    if (enc_count == 2'd2) begin
      grp    = {enc_held[0], enc_held[1], b};
      nchars = 4;
    end else begin
      enc_held[enc_count[0]] = b;
      if (!eom) begin
        enc_count = enc_count + 2'd1;
        return;
      end
      grp    = (enc_count == 2'd0) ? {b, 16'h0000} : {enc_held[0], b, 8'h00};
      nchars = int'(enc_count) + 2;
    end
    for (int k = 0; k < 4; k++) begin
      ch.out_char  = (k < nchars) ? alphabet_char(grp[23 - 6 * k -: 6]) : PAD_CHAR;
      ch.last_char = eom && (k == 3);
      pending_chars.push_back(ch);
    end
    enc_count = 2'd0;
  endfunction

  // Offers one byte and returns at the edge where the block takes it. The
  // prediction is made at that edge. Afterwards the input may go quiet for a
  // random burst; otherwise the next call raises the next request at once,
  // so valid never drops and rises within one step.
  task automatic send_byte(input logic [7:0] b, input logic eom);
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, end_of_message: eom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_into_pending(b, eom);
    bytes_sent++;
    if (eom) messages_sent++;
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Sends a whole message of random bytes. Now and then a byte is forced to
  // an extreme so that all-zero and all-one groups show up in random traffic.
  task automatic send_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Output side. A pending hold request wins and is counted down here at each
  // edge. Otherwise, when gaps are on, the output stalls in random bursts;
  // between bursts it takes every character.
  initial begin : output_side
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_stall    <= 1'b1;
        hold_request = hold_request - 1;
      end else if (out_gaps_on && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every character the block hands over is matched against the oldest
  // prediction. Outputs are read at the edge, before the block updates them.
  always @(posedge clk) begin : check_chars
    b64e_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t ns: unexpected character: expected none, actual char=%h last=%b",
                 $time, out_data.out_char, out_data.last_char);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data.out_char !== want.out_char) begin
          $display("%0t ns: out_char mismatch: expected %h, actual %h",
                   $time, want.out_char, out_data.out_char);
          errors++;
        end
        if (out_data.last_char !== want.last_char) begin
          $display("%0t ns: last_char mismatch: expected %b, actual %b",
                   $time, want.last_char, out_data.last_char);
          errors++;
        end
        chars_checked++;
      end
    end
  end

  // Fixed cases: one-byte and two-byte messages (double and single padding),
  // full groups with and without the end flag, groups that map to '+' and
  // '/', all-zero and all-one bytes, and a message that ends just after a
  // full group.
  task automatic test_directed();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'h4D, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h3F, 1'b1);
  endtask

  // Random messages, mostly short, with the idle pattern of each side
  // redrawn per message so that some stretches run with no gaps at all.
  task automatic test_random_messages(input int byte_goal);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) send_message($urandom_range(7, 20));
      else                           send_message($urandom_range(1, 6));
    end
  endtask

  // The output is held off for a long stretch while bytes keep coming, so
  // the group queue fills and the block has to stall its input.
  task automatic test_output_hold();
    in_gaps_on   = 1'b0;
    out_gaps_on  = 1'b0;
    hold_request = 80;
    send_message(11);
    send_message(13);
    send_message(6);
  endtask

  // Closing part at full rate on both sides.
  task automatic test_full_rate();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    send_message(3);
    send_message(1);
    send_message(17);
    send_message(2);
    send_message(9);
  endtask

  initial begin : run_tests
    int waited;
    errors        = 0;
    bytes_sent    = 0;
    messages_sent = 0;
    chars_checked = 0;
    hold_request  = 0;
    in_gaps_on    = 1'b0;
    out_gaps_on   = 1'b0;
    enc_count     = 2'd0;
    enc_held[0]   = 8'h00;
    enc_held[1]   = 8'h00;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_messages(240);
    test_output_hold();
    test_full_rate();
    in_valid <= 1'b0;

    // Drain: wait, with a bound, for every predicted character to appear,
    // then keeps waiting so that any extra character would be caught.
    waited = 0;
    while (pending_chars.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0t ns: %0d characters never arrived: expected %h, actual none",
               $time, pending_chars.size(), pending_chars[0].out_char);
      errors++;
    end

    $display("Encoded %0d bytes in %0d messages; %0d characters compared.",
             bytes_sent, messages_sent, chars_checked);
    $display("Included padded endings, full groups, a long output hold and full-rate runs.");
    if (errors == 0) begin
      $display("tb_base64_stream_encoder_unit OK");
    end else begin
      $display("tb_base64_stream_encoder_unit NOT OK");
    end
    $finish;
  end

  // Safety net far above the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Timed out with %0d characters outstanding.", pending_chars.size());
    $display("tb_base64_stream_encoder_unit NOT OK");
    $finish;
  end

endmodule
